### rtl/core/aqpf_pkg.sv
// ----------------------------------------------------------------------------
// aqpf_pkg
// Shared types, widths, register codes and reset values for the area query
// point filter.
// ----------------------------------------------------------------------------
package aqpf_pkg;

    // Default module parameters
    localparam int CIRCLE_BONUS_DEF = 50;
    localparam int COORD_BITS_DEF   = 20;

    // Fixed field widths
    localparam int TAG_W      = 16;
    localparam int MODE_W     = 2;
    localparam int FWD_W      = 16;
    localparam int REACH_W    = 19;
    localparam int COS_W      = 16;
    localparam int C2_W       = 2 * COS_W - 1;     // cos^2 is never above 2^30
    localparam int FRAC_W     = 15;                // Q1.15 scale of forward
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Pipeline depth: subtract, multiply, sum, magnitude, partial products,
    // combine, compare/decide
    localparam int NUM_STAGES = 7;

    // Register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE       = 3'd0,
        REG_CENTER_X   = 3'd1,
        REG_CENTER_Y   = 3'd2,
        REG_FORWARD_X  = 3'd3,
        REG_FORWARD_Y  = 3'd4,
        REG_REACH      = 3'd5,
        REG_COS_HALF   = 3'd6,
        REG_SIDE_LIMIT = 3'd7
    } t_cfg_idx;

    // Area shapes
    localparam logic [MODE_W-1:0] MODE_CIRCLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECTOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RECT   = 2'd2;

    // Reset values
    localparam logic signed [FWD_W-1:0] FWD_X_RST = 16'sd32767;
    localparam logic signed [COS_W-1:0] COS_RST   = 16'sd32767;

    // Configuration fields whose widths do not follow the coordinate width
    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [FWD_W-1:0]  fwd_x;
        logic signed [FWD_W-1:0]  fwd_y;
        logic [REACH_W-1:0]       reach;
        logic signed [COS_W-1:0]  cos_half;
        logic [REACH_W-1:0]       side_limit;
    } t_cfg_fixed;

    // Per-stage load enables
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    // Fields that ride along with each request
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             last;
        logic             ev;
    } t_item_meta;

endpackage

### rtl/core/aqpf_cfg.sv
// ----------------------------------------------------------------------------
// aqpf_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module aqpf_cfg #(
    parameter int COORD_BITS = aqpf_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aqpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aqpf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic signed [COORD_BITS-1:0]      o_center_x,
    output logic signed [COORD_BITS-1:0]      o_center_y,
    output aqpf_pkg::t_cfg_fixed              o_cfg
);
    import aqpf_pkg::*;

    logic signed [COORD_BITS-1:0] r_center_x;
    logic signed [COORD_BITS-1:0] r_center_y;
    t_cfg_fixed                   r_cfg;

    // Always ready; each write is registered and takes effect on the outputs in the next cycle
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x       <= '0;
            r_center_y       <= '0;
            r_cfg.mode       <= MODE_CIRCLE;
            r_cfg.fwd_x      <= FWD_X_RST;
            r_cfg.fwd_y      <= '0;
            r_cfg.reach      <= '0;
            r_cfg.cos_half   <= COS_RST;
            r_cfg.side_limit <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                REG_MODE:       r_cfg.mode       <= i_cfg_data[MODE_W-1:0];
                REG_CENTER_X:   r_center_x       <= i_cfg_data[COORD_BITS-1:0];
                REG_CENTER_Y:   r_center_y       <= i_cfg_data[COORD_BITS-1:0];
                REG_FORWARD_X:  r_cfg.fwd_x      <= i_cfg_data[FWD_W-1:0];
                REG_FORWARD_Y:  r_cfg.fwd_y      <= i_cfg_data[FWD_W-1:0];
                REG_REACH:      r_cfg.reach      <= i_cfg_data[REACH_W-1:0];
                REG_COS_HALF:   r_cfg.cos_half   <= i_cfg_data[COS_W-1:0];
                REG_SIDE_LIMIT: r_cfg.side_limit <= i_cfg_data[REACH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_center_x = r_center_x;
    assign o_center_y = r_center_y;
    assign o_cfg      = r_cfg;

endmodule

### rtl/core/aqpf_ctrl.sv
// ----------------------------------------------------------------------------
// aqpf_ctrl
// Valid bits and load enables of the pipeline; a stage loads when it is
// empty or when the stage after it moves, so bubbles collapse under stall.
// ----------------------------------------------------------------------------
module aqpf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    output logic                 o_valid,
    input  logic                 i_stall,
    output aqpf_pkg::t_pipe_ctl  o_ctl
);
    import aqpf_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] rdy;

    // Ready ripples back from the output
    always_comb begin
        rdy[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign n_vld = {r_vld[NUM_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign o_ctl.en = rdy;
    assign o_stall  = !rdy[0];
    assign o_valid  = r_vld[NUM_STAGES-1];

endmodule

### rtl/core/aqpf_geom.sv
// ----------------------------------------------------------------------------
// aqpf_geom
// Front stages: offset from the center, products, then squared distance,
// forward (dot) and side projections.
// ----------------------------------------------------------------------------
module aqpf_geom #(
    parameter int COORD_BITS   = aqpf_pkg::COORD_BITS_DEF,
    parameter int CIRCLE_BONUS = aqpf_pkg::CIRCLE_BONUS_DEF
) (
    input  logic                                     i_clk,
    input  aqpf_pkg::t_pipe_ctl                      i_ctl,
    input  aqpf_pkg::t_item_meta                     i_meta,
    input  logic signed [COORD_BITS-1:0]             i_pos_x,
    input  logic signed [COORD_BITS-1:0]             i_pos_y,
    input  logic signed [COORD_BITS-1:0]             i_center_x,
    input  logic signed [COORD_BITS-1:0]             i_center_y,
    input  aqpf_pkg::t_cfg_fixed                     i_cfg,
    output aqpf_pkg::t_item_meta                     o_meta,
    output logic [2*COORD_BITS:0]                    o_d2,
    output logic signed [COORD_BITS+16:0]            o_dot,
    output logic signed [COORD_BITS+16:0]            o_side,
    output logic [2*aqpf_pkg::REACH_W+1:0]           o_r2c,
    output logic [2*aqpf_pkg::REACH_W-1:0]           o_r2r,
    output logic [aqpf_pkg::C2_W-1:0]                o_c2
);
    import aqpf_pkg::*;

    localparam int DW    = COORD_BITS + 1;        // offset width
    localparam int SQW   = 2 * COORD_BITS;        // one squared offset
    localparam int D2W   = SQW + 1;               // squared distance
    localparam int PW    = FWD_W + DW;            // forward x offset product
    localparam int RBW   = REACH_W + 1;           // reach plus bonus
    localparam int R2C_W = 2 * RBW;
    localparam int R2R_W = 2 * REACH_W;
    localparam logic [RBW-1:0] BONUS = RBW'(CIRCLE_BONUS);

    // Stage 1 registers
    t_item_meta            r1_meta;
    logic signed [DW-1:0]  r1_dx;
    logic signed [DW-1:0]  r1_dy;

    // Stage 2 registers
    t_item_meta            r2_meta;
    logic [SQW-1:0]        r2_sqx;
    logic [SQW-1:0]        r2_sqy;
    logic signed [PW-1:0]  r2_fxdx;
    logic signed [PW-1:0]  r2_fydy;
    logic signed [PW-1:0]  r2_fxdy;
    logic signed [PW-1:0]  r2_fydx;
    logic [R2C_W-1:0]      r2_r2c;
    logic [R2R_W-1:0]      r2_r2r;
    logic [C2_W-1:0]       r2_c2;

    // Stage 3 registers
    t_item_meta            r3_meta;
    logic [D2W-1:0]        r3_d2;
    logic signed [PW-1:0]  r3_dot;
    logic signed [PW-1:0]  r3_side;
    logic [R2C_W-1:0]      r3_r2c;
    logic [R2R_W-1:0]      r3_r2r;
    logic [C2_W-1:0]       r3_c2;

    logic signed [2*DW-1:0]     sqx_full;
    logic signed [2*DW-1:0]     sqy_full;
    logic [RBW-1:0]             reach_b;
    logic signed [2*COS_W-1:0]  c2_full;

    // Stage 1: offsets from the center
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r1_meta <= i_meta;
            r1_dx   <= DW'(i_pos_x) - DW'(i_center_x);
            r1_dy   <= DW'(i_pos_y) - DW'(i_center_y);
        end
    end

    // Stage 2: one multiplier per product, plus the configured limits squared
    assign sqx_full = r1_dx * r1_dx;
    assign sqy_full = r1_dy * r1_dy;
    assign reach_b  = RBW'(i_cfg.reach) + BONUS;
    assign c2_full  = i_cfg.cos_half * i_cfg.cos_half;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r2_meta <= r1_meta;
            r2_sqx  <= sqx_full[SQW-1:0];
            r2_sqy  <= sqy_full[SQW-1:0];
            r2_fxdx <= i_cfg.fwd_x * r1_dx;
            r2_fydy <= i_cfg.fwd_y * r1_dy;
            r2_fxdy <= i_cfg.fwd_x * r1_dy;
            r2_fydx <= i_cfg.fwd_y * r1_dx;
            r2_r2c  <= reach_b * reach_b;
            r2_r2r  <= i_cfg.reach * i_cfg.reach;
            r2_c2   <= c2_full[C2_W-1:0];
        end
    end

    // Stage 3: sums; dot and side stay below 2^(COORD_BITS+16) in magnitude
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r3_meta <= r2_meta;
            r3_d2   <= D2W'(r2_sqx) + D2W'(r2_sqy);
            r3_dot  <= r2_fxdx + r2_fydy;
            r3_side <= r2_fxdy - r2_fydx;
            r3_r2c  <= r2_r2c;
            r3_r2r  <= r2_r2r;
            r3_c2   <= r2_c2;
        end
    end

    assign o_meta = r3_meta;
    assign o_d2   = r3_d2;
    assign o_dot  = r3_dot;
    assign o_side = r3_side;
    assign o_r2c  = r3_r2c;
    assign o_r2r  = r3_r2r;
    assign o_c2   = r3_c2;

endmodule

### rtl/core/aqpf_test.sv
// ----------------------------------------------------------------------------
// aqpf_test
// Back stages: magnitudes, distance and rectangle compares, the exact sector
// angle test dot^2 against cos^2 * d2 from split products, and the result.
// ----------------------------------------------------------------------------
module aqpf_test #(
    parameter int COORD_BITS = aqpf_pkg::COORD_BITS_DEF
) (
    input  logic                                     i_clk,
    input  aqpf_pkg::t_pipe_ctl                      i_ctl,
    input  aqpf_pkg::t_cfg_fixed                     i_cfg,
    input  aqpf_pkg::t_item_meta                     i_meta,
    input  logic [2*COORD_BITS:0]                    i_d2,
    input  logic signed [COORD_BITS+16:0]            i_dot,
    input  logic signed [COORD_BITS+16:0]            i_side,
    input  logic [2*aqpf_pkg::REACH_W+1:0]           i_r2c,
    input  logic [2*aqpf_pkg::REACH_W-1:0]           i_r2r,
    input  logic [aqpf_pkg::C2_W-1:0]                i_c2,
    output logic [aqpf_pkg::TAG_W-1:0]               o_result_tag,
    output logic                                     o_inside_res,
    output logic                                     o_result_last
);
    import aqpf_pkg::*;

    localparam int D2W   = 2 * COORD_BITS + 1;
    localparam int PW    = COORD_BITS + 17;
    localparam int MW    = PW - 1;                  // magnitude of dot or side
    localparam int R2C_W = 2 * REACH_W + 2;
    localparam int R2R_W = 2 * REACH_W;
    localparam int CW    = (D2W > R2C_W) ? D2W : R2C_W;
    localparam int LIMW  = REACH_W + FRAC_W;
    localparam int LW    = (MW > LIMW) ? MW : LIMW;
    localparam int ML    = MW / 2;
    localparam int MH    = MW - ML;
    localparam int DL    = (D2W + 1) / 2;
    localparam int DH    = D2W - DL;
    localparam int EW    = 2 * MW;                  // equals C2_W + D2W

    // Stage 4 registers
    t_item_meta            r4_meta;
    logic [MW-1:0]         r4_mdot;
    logic [MW-1:0]         r4_mside;
    logic [D2W-1:0]        r4_d2;
    logic [C2_W-1:0]       r4_c2;
    logic                  r4_circ_ok;
    logic                  r4_dist_ok;
    logic                  r4_d2_zero;
    logic                  r4_dot_neg;

    // Stage 5 registers
    t_item_meta            r5_meta;
    logic [2*MH-1:0]       r5_hh;
    logic [MH+ML-1:0]      r5_hl;
    logic [2*ML-1:0]       r5_ll;
    logic [C2_W+DH-1:0]    r5_cdh;
    logic [C2_W+DL-1:0]    r5_cdl;
    logic                  r5_circ_ok;
    logic                  r5_dist_ok;
    logic                  r5_rect_ok;
    logic                  r5_d2_zero;
    logic                  r5_dot_neg;

    // Stage 6 registers
    t_item_meta            r6_meta;
    logic [EW-1:0]         r6_dd;
    logic [EW-1:0]         r6_cc;
    logic                  r6_circ_ok;
    logic                  r6_dist_ok;
    logic                  r6_rect_ok;
    logic                  r6_d2_zero;
    logic                  r6_dot_neg;

    // Stage 7 (output) registers
    logic [TAG_W-1:0]      r7_tag;
    logic                  r7_last;
    logic                  r7_inside;

    logic signed [PW-1:0]  neg_dot;
    logic signed [PW-1:0]  neg_side;
    logic [MW-1:0]         mh_bits;
    logic [MW-1:0]         ml_bits;
    logic                  angle_ok;
    logic                  hit;

    // Stage 4: magnitudes and distance compares
    assign neg_dot  = -i_dot;
    assign neg_side = -i_side;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r4_meta    <= i_meta;
            r4_mdot    <= i_dot[PW-1]  ? neg_dot[MW-1:0]  : i_dot[MW-1:0];
            r4_mside   <= i_side[PW-1] ? neg_side[MW-1:0] : i_side[MW-1:0];
            r4_d2      <= i_d2;
            r4_c2      <= i_c2;
            r4_circ_ok <= CW'(i_d2) <= CW'(i_r2c);
            r4_dist_ok <= CW'(i_d2) <= CW'(i_r2r);
            r4_d2_zero <= (i_d2 == '0);
            r4_dot_neg <= i_dot[PW-1];
        end
    end

    // Stage 5: rectangle limits and split products
    assign mh_bits = r4_mdot >> ML;
    assign ml_bits = r4_mdot & MW'((1 << ML) - 1);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r5_meta    <= r4_meta;
            r5_hh      <= mh_bits[MH-1:0] * mh_bits[MH-1:0];
            r5_hl      <= mh_bits[MH-1:0] * ml_bits[ML-1:0];
            r5_ll      <= ml_bits[ML-1:0] * ml_bits[ML-1:0];
            r5_cdh     <= r4_c2 * r4_d2[D2W-1:DL];
            r5_cdl     <= r4_c2 * r4_d2[DL-1:0];
            r5_rect_ok <= (LW'(r4_mdot)  <= (LW'(i_cfg.reach)      << FRAC_W))
                       && (LW'(r4_mside) <= (LW'(i_cfg.side_limit) << FRAC_W));
            r5_circ_ok <= r4_circ_ok;
            r5_dist_ok <= r4_dist_ok;
            r5_d2_zero <= r4_d2_zero;
            r5_dot_neg <= r4_dot_neg;
        end
    end

    // Stage 6: assemble dot^2 and cos^2 * d2
    always_ff @(posedge i_clk) begin
        if (i_ctl.en[5]) begin
            r6_meta    <= r5_meta;
            r6_dd      <= (EW'(r5_hh) << (2 * ML)) + (EW'(r5_hl) << (ML + 1))
                        + EW'(r5_ll);
            r6_cc      <= (EW'(r5_cdh) << DL) + EW'(r5_cdl);
            r6_circ_ok <= r5_circ_ok;
            r6_dist_ok <= r5_dist_ok;
            r6_rect_ok <= r5_rect_ok;
            r6_d2_zero <= r5_d2_zero;
            r6_dot_neg <= r5_dot_neg;
        end
    end

    // Stage 7: angle decision by sign of cos and dot, then mode select
    always_comb begin
        if (r6_d2_zero) begin
            // entity at the center passes only for a non-positive cosine
            angle_ok = (i_cfg.cos_half <= 0);
        end else if (i_cfg.cos_half >= 0) begin
            angle_ok = !r6_dot_neg && (r6_dd >= r6_cc);
        end else begin
            angle_ok = !r6_dot_neg || (r6_dd <= r6_cc);
        end

        case (i_cfg.mode)
            MODE_CIRCLE: hit = r6_circ_ok;
            MODE_SECTOR: hit = r6_dist_ok && angle_ok;
            MODE_RECT:   hit = r6_rect_ok;
            default:     hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[6]) begin
            r7_tag    <= r6_meta.tag;
            r7_last   <= r6_meta.last;
            r7_inside <= r6_meta.ev && hit;
        end
    end

    assign o_result_tag  = r7_tag;
    assign o_inside_res  = r7_inside;
    assign o_result_last = r7_last;

endmodule

### rtl/core/area_query_point_filter.sv
// Throughput: one request per cycle while the output does not stall; each of the
// seven register stages (offset, products, sums, magnitudes, split products,
// combine, decide) loads when the stage ahead has room, so a stalled output fills
// the pipe and bubbles are squeezed out before the input stalls.
// Reset: clears all stage valid bits; configuration returns to its defaults.
// ----------------------------------------------------------------------------
// area_query_point_filter
// Flags each entity position that lies inside a configured circle, sector
// or oriented rectangle around a query center.
// ----------------------------------------------------------------------------
module area_query_point_filter #(
    parameter int CIRCLE_BONUS = aqpf_pkg::CIRCLE_BONUS_DEF,
    parameter int COORD_BITS   = aqpf_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [aqpf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [aqpf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // Entity requests
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [aqpf_pkg::TAG_W-1:0]        i_entity_tag,
    input  logic signed [COORD_BITS-1:0]      i_pos_x,
    input  logic signed [COORD_BITS-1:0]      i_pos_y,
    input  logic                              i_entry_valid,
    input  logic                              i_last_entry,
    // Results
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [aqpf_pkg::TAG_W-1:0]        o_result_tag,
    output logic                              o_inside_res,
    output logic                              o_result_last
);
    import aqpf_pkg::*;

    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    t_cfg_fixed                    cfg;
    t_pipe_ctl                     ctl;
    t_item_meta                    in_meta;
    t_item_meta                    g_meta;
    logic [2*COORD_BITS:0]         g_d2;
    logic signed [COORD_BITS+16:0] g_dot;
    logic signed [COORD_BITS+16:0] g_side;
    logic [2*REACH_W+1:0]          g_r2c;
    logic [2*REACH_W-1:0]          g_r2r;
    logic [C2_W-1:0]               g_c2;

    assign in_meta.tag  = i_entity_tag;
    assign in_meta.last = i_last_entry;
    assign in_meta.ev   = i_entry_valid;

    aqpf_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_center_x  (center_x),
        .o_center_y  (center_y),
        .o_cfg       (cfg)
    );

    aqpf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    aqpf_geom #(
        .COORD_BITS   (COORD_BITS),
        .CIRCLE_BONUS (CIRCLE_BONUS)
    ) u_geom (
        .i_clk      (i_clk),
        .i_ctl      (ctl),
        .i_meta     (in_meta),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_center_x (center_x),
        .i_center_y (center_y),
        .i_cfg      (cfg),
        .o_meta     (g_meta),
        .o_d2       (g_d2),
        .o_dot      (g_dot),
        .o_side     (g_side),
        .o_r2c      (g_r2c),
        .o_r2r      (g_r2r),
        .o_c2       (g_c2)
    );

    aqpf_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk         (i_clk),
        .i_ctl         (ctl),
        .i_cfg         (cfg),
        .i_meta        (g_meta),
        .i_d2          (g_d2),
        .i_dot         (g_dot),
        .i_side        (g_side),
        .i_r2c         (g_r2c),
        .i_r2r         (g_r2r),
        .i_c2          (g_c2),
        .o_result_tag  (o_result_tag),
        .o_inside_res  (o_inside_res),
        .o_result_last (o_result_last)
    );

endmodule

### tb/sv/tb_area_query_point_filter.sv
// ----------------------------------------------------------------------------
// tb_area_query_point_filter
// Self-checking bench for the area query point filter. Entity requests are
// streamed through the block under circle, sector, oriented rectangle and
// unused area settings. Each accepted request is run through an exact integer
// predictor, and every result is checked in order. Both handshake sides
// stall at random, and the run ends with a stretch that has no stalls.
// ----------------------------------------------------------------------------
module tb_area_query_point_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import aqpf_pkg::*;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int NUM_PHASES = 10;
    localparam int LONG_HOLD = 60;
    localparam int LONG_HOLD_AT = 250;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int COORD_MIN = -(1 << (COORD_W - 1));
    localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic             hit;
        logic             last;
    } t_hit_result;

    // Area registers, hit predictor and in-order store of expected results
    class area_hit_scoreboard;
        logic [MODE_W-1:0]        mode;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [FWD_W-1:0]  fx;
        logic signed [FWD_W-1:0]  fy;
        logic [REACH_W-1:0]       reach;
        logic signed [COS_W-1:0]  cos_half;
        logic [REACH_W-1:0]       side_limit;
        t_hit_result              expected_hits[$];
        int                       errors;

        function new();
            mode       = MODE_CIRCLE;
            cx         = '0;
            cy         = '0;
            fx         = FWD_X_RST;
            fy         = '0;
            reach      = '0;
            cos_half   = COS_RST;
            side_limit = '0;
            errors     = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:       mode       = data[MODE_W-1:0];
                REG_CENTER_X:   cx         = data[COORD_W-1:0];
                REG_CENTER_Y:   cy         = data[COORD_W-1:0];
                REG_FORWARD_X:  fx         = data[FWD_W-1:0];
                REG_FORWARD_Y:  fy         = data[FWD_W-1:0];
                REG_REACH:      reach      = data[REACH_W-1:0];
                REG_COS_HALF:   cos_half   = data[COS_W-1:0];
                REG_SIDE_LIMIT: side_limit = data[REACH_W-1:0];
                default: ;
            endcase
        endfunction

        function logic signed [127:0] magnitude(logic signed [127:0] v);
            return (v < 0) ? -v : v;
        endfunction

        // Exact test: no square roots, everything squared in 128 bits
        function bit point_in_area(logic signed [COORD_W-1:0] px,
                                   logic signed [COORD_W-1:0] py);
            logic signed [127:0] dx, dy, d2, dot, across, lim, dd, cc, cw;
            bit hit;
            dx     = px - cx;
            dy     = py - cy;
            d2     = dx * dx + dy * dy;
            dot    = fx * dx + fy * dy;
            across = fx * dy - fy * dx;
            cw     = cos_half;
            hit    = 1'b0;
            case (mode)
                MODE_CIRCLE: begin
                    lim = reach;
                    lim = lim + CIRCLE_BONUS_DEF;
                    hit = (d2 <= lim * lim);
                end
                MODE_SECTOR: begin
                    // dot >= cos * |d|, sign cases handled before squaring
                    if (d2 == 0) begin
                        hit = (cw <= 0);
                    end else begin
                        dd = dot * dot;
                        cc = cw * cw * d2;
                        if (cw >= 0)
                            hit = (dot >= 0) && (dd >= cc);
                        else
                            hit = (dot >= 0) || (dd <= cc);
                    end
                    lim = reach;
                    hit = hit && (d2 <= lim * lim);
                end
                MODE_RECT: begin
                    lim = reach;
                    hit = (magnitude(dot) <= lim * 32768);
                    lim = side_limit;
                    hit = hit && (magnitude(across) <= lim * 32768);
                end
                default: hit = 1'b0;
            endcase
            return hit;
        endfunction

        function void note_request(logic [TAG_W-1:0] tag, logic signed [COORD_W-1:0] px,
                                   logic signed [COORD_W-1:0] py, logic ev, logic last);
            t_hit_result r;
            r.tag  = tag;
            r.hit  = ev && point_in_area(px, py);
            r.last = last;
            expected_hits.push_back(r);
        endfunction

        function void check_result(logic [TAG_W-1:0] tag, logic hit, logic last);
            t_hit_result e;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tag %h hit %b last %b",
                         $time, tag, hit, last);
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            if (tag !== e.tag) begin
                $display("%0t: result_tag mismatch, expected %h, actual %h",
                         $time, e.tag, tag);
                errors++;
            end
            if (hit !== e.hit) begin
                $display("%0t: inside_res mismatch (tag %h), expected %b, actual %b",
                         $time, e.tag, e.hit, hit);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: result_last mismatch (tag %h), expected %b, actual %b",
                         $time, e.tag, e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [TAG_W-1:0]           i_entity_tag = '0;
    logic signed [COORD_W-1:0]  i_pos_x = '0;
    logic signed [COORD_W-1:0]  i_pos_y = '0;
    logic                       i_entry_valid = 1'b0;
    logic                       i_last_entry = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [TAG_W-1:0]           o_result_tag;
    logic                       o_inside_res;
    logic                       o_result_last;

    area_hit_scoreboard area_sb = new();
    logic quiet = 1'b0;     // no stalls on either side once set
    bit   calm = 1'b0;      // sender offers back to back
    int   results_seen = 0;
    int   hold_left = 0;
    int   burst_left = 0;
    bit   long_hold_done = 1'b0;
    int   idle_cycles = 0;

    area_query_point_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_entity_tag  (i_entity_tag),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_entry_valid (i_entry_valid),
        .i_last_entry  (i_last_entry),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_result_tag  (o_result_tag),
        .o_inside_res  (o_inside_res),
        .o_result_last (o_result_last)
    );

    always #1 i_clk = ~i_clk;

    // Result side: check, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (o_valid && !i_stall) begin
            area_sb.check_result(o_result_tag, o_inside_res, o_result_last);
            results_seen++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
            // long hold-off so the pipeline backs up into the request side
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(1, 8) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Offer one request and hold it until taken; valid stays high afterwards
    task automatic send_entity(input logic [TAG_W-1:0] tag,
                               input logic signed [COORD_W-1:0] px,
                               input logic signed [COORD_W-1:0] py,
                               input logic ev, input logic last);
        i_valid       <= 1'b1;
        i_entity_tag  <= tag;
        i_pos_x       <= px;
        i_pos_y       <= py;
        i_entry_valid <= ev;
        i_last_entry  <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        area_sb.note_request(tag, px, py, ev, last);
    endtask

    task automatic sender_gap();
        if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_done();
        i_valid <= 1'b0;
        while (area_sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        area_sb.write_reg(idx, value);
    endtask

    // Full register set, back to back; only called with the pipeline empty
    task automatic write_area(input int mode, input int cxv, input int cyv, input int fxv,
                              input int fyv, input int rv, input int cv, input int sv);
        write_reg(REG_MODE, mode);
        write_reg(REG_CENTER_X, cxv);
        write_reg(REG_CENTER_Y, cyv);
        write_reg(REG_FORWARD_X, fxv);
        write_reg(REG_FORWARD_Y, fyv);
        write_reg(REG_REACH, rv);
        write_reg(REG_COS_HALF, cv);
        write_reg(REG_SIDE_LIMIT, sv);
        i_cfg_valid <= 1'b0;
    endtask

    // Log-spread size so both tiny and huge areas come up
    function automatic int rand_size();
        int b;
        b = $urandom_range(0, REACH_W);
        return (b == 0) ? 0 : int'($urandom_range(0, (1 << b) - 1));
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, (1 << COORD_W) - 1)) + COORD_MIN;
    endfunction

    task automatic pick_area(input int p);
        int  m, cxv, cyv, fxv, fyv, rv, cv, sv;
        real ang;
        m   = p % 4;
        cxv = rand_coord();
        cyv = rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            // forward not of unit length
            fxv = int'($urandom_range(0, 65534)) - 32767;
            fyv = int'($urandom_range(0, 65534)) - 32767;
        end else begin
            ang = $urandom_range(0, 35999) * 6.283185307 / 36000.0;
            fxv = $rtoi(32767.0 * $cos(ang));
            fyv = $rtoi(32767.0 * $sin(ang));
        end
        if ($urandom_range(0, 1) == 0)
            cv = $rtoi(32767.0 * $cos($urandom_range(0, 3141) / 1000.0));
        else
            cv = int'($urandom_range(0, 65535)) - 32768;
        rv = rand_size();
        sv = rand_size();
        // extreme settings on a few phases
        case (p)
            1: begin
                cv = 32767; fxv = 32767; fyv = 0; rv = 524287;
                cxv = COORD_MAX; cyv = COORD_MIN;
            end
            2: begin
                rv = 524287; sv = 524287; fxv = -32767; fyv = -32767;
                cxv = COORD_MIN; cyv = COORD_MAX;
            end
            5: begin
                cv = -32768; rv = 0;
            end
            6: begin
                rv = 0; sv = 0;
            end
            default: ;
        endcase
        write_area(m, cxv, cyv, fxv, fyv, rv, cv, sv);
    endtask

    function automatic int edge_coord(input int centre);
        case ($urandom_range(0, 3))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            default: return centre;
        endcase
    endfunction

    // Mostly points around the area boundary, some anywhere, some extremes
    task automatic random_entity();
        int               span, sel, xv, yv, r, s;
        logic [TAG_W-1:0] tag;
        logic             ev, last;
        tag  = TAG_W'($urandom_range(0, 65535));
        ev   = ($urandom_range(0, 9) != 0);
        last = ($urandom_range(0, 9) == 0);
        r    = int'(area_sb.reach);
        s    = int'(area_sb.side_limit);
        span = ((r > s) ? r : s) + r / 2 + 64;
        sel  = $urandom_range(0, 9);
        if (sel < 6) begin
            xv = int'(area_sb.cx) + int'($urandom_range(0, 2 * span)) - span;
            yv = int'(area_sb.cy) + int'($urandom_range(0, 2 * span)) - span;
        end else if (sel < 8) begin
            xv = rand_coord();
            yv = rand_coord();
        end else begin
            xv = edge_coord(int'(area_sb.cx));
            yv = edge_coord(int'(area_sb.cy));
        end
        // points past the coordinate range wrap around
        send_entity(tag, COORD_W'(xv), COORD_W'(yv), ev, last);
    endtask

    // Stimulus
    initial begin
        int n;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Circle at reset defaults: radius is just the bonus
        send_entity(16'h0000, 0, 0, 1'b1, 1'b0);
        send_entity(16'h0001, 50, 0, 1'b1, 1'b0);
        send_entity(16'h0002, 0, -51, 1'b1, 1'b0);
        send_entity(16'hFFFF, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
        send_entity(16'h8000, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        send_entity(16'h00AA, 0, 0, 1'b0, 1'b1);   // dead entity at the centre
        wait_all_done();

        // Sector facing +y, 90 degree half angle: centre, ahead, behind, side edge
        write_area(MODE_SECTOR, 1000, -1000, 0, 32767, 500, 0, 0);
        send_entity(16'h0101, 1000, -1000, 1'b1, 1'b0);
        send_entity(16'h0102, 1000, -500, 1'b1, 1'b0);
        send_entity(16'h0103, 1000, -1500, 1'b1, 1'b0);
        send_entity(16'h0104, 1500, -1000, 1'b1, 1'b1);
        wait_all_done();

        // Sector with the most negative cosine: centre and behind
        write_area(MODE_SECTOR, 1000, -1000, 0, 32767, 500, -32768, 0);
        send_entity(16'h0201, 1000, -1000, 1'b1, 1'b0);
        send_entity(16'h0202, 1000, -1400, 1'b1, 1'b1);
        wait_all_done();

        // Sector with the largest cosine: centre misses, dead ahead sits on the edge
        write_area(MODE_SECTOR, 1000, -1000, 0, 32767, 500, 32767, 0);
        send_entity(16'h0301, 1000, -1000, 1'b1, 1'b0);
        send_entity(16'h0302, 1000, -600, 1'b1, 1'b1);
        wait_all_done();

        // Oriented rectangle along +x: corners and just past the front
        write_area(MODE_RECT, 0, 0, 32767, 0, 100, 32767, 20);
        send_entity(16'h0401, 100, 20, 1'b1, 1'b0);
        send_entity(16'h0402, 101, 0, 1'b1, 1'b0);
        send_entity(16'h0403, -100, -20, 1'b1, 1'b1);
        wait_all_done();

        // Unused mode value never hits
        write_area(MODE_UNUSED, 0, 0, 32767, 0, 100, 0, 100);
        send_entity(16'h0501, 0, 0, 1'b1, 1'b1);

        // Random phases, one area setting each
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_all_done();
            if (p == NUM_PHASES - 1)
                quiet <= 1'b1;
            calm = (p == 6);
            pick_area(p);
            n = (p % 4 == 3) ? 20 : 95;
            for (int i = 0; i < n; i++) begin
                random_entity();
                sender_gap();
            end
        end

        wait_all_done();
        repeat (NUM_STAGES + 5) @(posedge i_clk);
        if (area_sb.pending() != 0)
            $display("%0t: %0d expected results never arrived", $time, area_sb.pending());
        if (area_sb.errors == 0 && area_sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
